// ===== rtl/core/tpsv_pkg.sv =====
// Shared types, codes and an arithmetic helper for the tensor parallel shard view.
// No dependencies.
package tpsv_pkg;

    localparam int MAX_RANK_DEF = 4;
    localparam int DIM_W        = 32;
    localparam int WIDE_W       = 64;
    localparam int DVS_W        = 36;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_FAILED      = 2'd3;

    localparam logic [2:0] CL_UNKNOWN    = 3'd0;
    localparam logic [2:0] CL_REPLICATED = 3'd1;
    localparam logic [2:0] CL_OUT_HEADS  = 3'd2;
    localparam logic [2:0] CL_IN_HEADS   = 3'd3;
    localparam logic [2:0] CL_OUT_DIM    = 3'd4;
    localparam logic [2:0] CL_IN_DIM     = 3'd5;
    localparam logic [2:0] CL_CONCAT     = 3'd6;

    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_RANK   = 2'd1;
    localparam logic [1:0] REG_HEADS  = 2'd2;
    localparam logic [1:0] REG_BLOCK  = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic              need_div;
        logic              rank0;
        logic              axis;
        logic [2:0]        k;
        logic [3:0]        rank;
        logic [7:0]        e;
        logic [DIM_W-1:0]  len;
        logic [DVS_W-1:0]  dvs;
        logic [DIM_W-1:0]  outer;
        logic [DIM_W-1:0]  f1;
        logic [DIM_W-1:0]  f2;
        logic [DIM_W-1:0]  f3;
    } t_item;

    typedef struct packed {
        t_item             it;
        logic [WIDE_W-1:0] inner;
        logic [WIDE_W-1:0] row;
        logic [WIDE_W-1:0] chunk;
        logic [WIDE_W-1:0] choff;
        logic [WIDE_W-1:0] total;
    } t_prod;

    function automatic logic [WIDE_W-1:0] mul_wrap(input logic [WIDE_W-1:0] x,
                                                   input logic [DIM_W-1:0]  y);
        logic [WIDE_W-1:0] lo;
        logic [WIDE_W-1:0] hi;
        lo = x[31:0] * y;
        hi = x[63:32] * y;
        return lo + {hi[31:0], 32'd0};
    endfunction

endpackage

// ===== rtl/core/tensor_parallel_shard_view_top.sv =====
// Top level of the tensor parallel shard view: decode, pipelined remainder check, products.
// Depends on tpsv_pkg.
//
// One descriptor is taken in every cycle (busy stays low). Its result is on the result
// ports, marked by o_valid, after it has passed through these registers in order:
// the input register, the remainder check (a restoring divider with one dividend bit per
// stage over 32 stages), five multiply stages for the 64-bit wrapping products and the
// output register. The result is shown for one cycle only; the receiver cannot stall it.
module tensor_parallel_shard_view_top #(
    parameter int P_MAX_RANK = tpsv_pkg::MAX_RANK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_tensor_rank,
    input  logic [31:0] i_dim0,
    input  logic [31:0] i_dim1,
    input  logic [31:0] i_dim2,
    input  logic [31:0] i_dim3,
    input  logic [7:0]  i_elem_bytes,
    input  logic [2:0]  i_shard_class,
    input  logic [31:0] i_head_block_elems,
    output logic        o_valid,
    output logic [1:0]  o_status_code,
    output logic        o_split_dim,
    output logic [63:0] o_shard_offset_elems,
    output logic [63:0] o_shard_extent_elems,
    output logic [63:0] o_shard_size_bytes,
    output logic [63:0] o_outer_row_count,
    output logic [63:0] o_row_pitch,
    output logic [63:0] o_chunk_size,
    output logic [63:0] o_chunk_offset
);
    import tpsv_pkg::*;

    localparam int LIMIT = (P_MAX_RANK < 4) ? P_MAX_RANK : 4;
    localparam int NDIV  = DIM_W;

    logic [4:0]  r_degree;
    logic [3:0]  r_rank;
    logic [15:0] r_heads;
    logic [31:0] r_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 5'd1;
            r_rank   <= 4'd0;
            r_heads  <= 16'd1;
            r_block  <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEGREE: r_degree <= i_cfg_data[4:0];
                REG_RANK:   r_rank   <= i_cfg_data[3:0];
                REG_HEADS:  r_heads  <= i_cfg_data[15:0];
                REG_BLOCK:  r_block  <= i_cfg_data;
                default:    r_degree <= r_degree;
            endcase
        end
    end

    assign busy = 1'b0;

    t_item      n_item;
    logic       deg_ok;
    logic [2:0] k;
    logic [15:0] mask;
    logic [2:0] cls;
    logic       whole;
    logic       axis;
    logic [31:0] blk;
    logic [31:0] dm1, dm2, dm3;

    always_comb begin
        deg_ok = 1'b1;
        case (r_degree)
            5'd1:    k = 3'd0;
            5'd2:    k = 3'd1;
            5'd4:    k = 3'd2;
            5'd8:    k = 3'd3;
            5'd16:   k = 3'd4;
            default: begin
                k = 3'd0;
                deg_ok = 1'b0;
            end
        endcase
        mask = (16'd1 << k) - 16'd1;
        cls = (i_shard_class == 3'd7) ? CL_UNKNOWN : i_shard_class;
        whole = (r_degree == 5'd1) || (cls == CL_REPLICATED);
        case (cls)
            CL_OUT_HEADS: begin axis = 1'b0; blk = i_head_block_elems; end
            CL_IN_HEADS:  begin axis = 1'b1; blk = r_block;            end
            CL_IN_DIM:    begin axis = 1'b1; blk = 32'd1;              end
            default:      begin axis = 1'b0; blk = 32'd1;              end
        endcase
        if (whole) begin
            axis = 1'b0;
        end
        dm1 = (i_tensor_rank > 3'd1) ? i_dim1 : 32'd1;
        dm2 = (i_tensor_rank > 3'd2) ? i_dim2 : 32'd1;
        dm3 = (i_tensor_rank > 3'd3) ? i_dim3 : 32'd1;

        n_item.need_div = 1'b0;
        if (!deg_ok || ({1'b0, r_rank} >= r_degree) || (r_heads == 16'd0)
                || ((r_heads & mask) != 16'd0) || (32'(i_tensor_rank) > LIMIT)) begin
            n_item.status = ST_INVALID;
        end else if (cls == CL_CONCAT) begin
            n_item.status = ST_UNSUPPORTED;
        end else if (whole) begin
            n_item.status = ST_OK;
        end else if (cls == CL_UNKNOWN) begin
            n_item.status = ST_FAILED;
        end else if ((i_tensor_rank < 3'd2) || (blk == 32'd0)) begin
            n_item.status = ST_INVALID;
        end else begin
            n_item.status   = ST_OK;
            n_item.need_div = 1'b1;
        end
        n_item.rank0 = whole && (i_tensor_rank == 3'd0);
        n_item.axis  = axis;
        n_item.k     = whole ? 3'd0 : k;
        n_item.rank  = whole ? 4'd0 : r_rank;
        n_item.e     = i_elem_bytes;
        n_item.len   = axis ? i_dim1 : i_dim0;
        n_item.dvs   = n_item.need_div ? ({4'd0, blk} << k) : 36'd1;
        n_item.outer = axis ? i_dim0 : 32'd1;
        n_item.f1    = axis ? dm2 : dm1;
        n_item.f2    = axis ? dm3 : dm2;
        n_item.f3    = axis ? 32'd1 : dm3;
    end

    t_item            r_div_item [0:NDIV];
    logic [DVS_W-1:0] r_div_rem  [0:NDIV];
    logic             r_div_v    [0:NDIV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_v[0] <= 1'b0;
        end else begin
            r_div_v[0] <= start;
        end
        r_div_item[0] <= n_item;
        r_div_rem[0]  <= '0;
    end

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        logic [DVS_W:0] n_rem;
        always_comb begin
            n_rem = {r_div_rem[g], r_div_item[g].len[NDIV-1-g]};
            if (n_rem >= {1'b0, r_div_item[g].dvs}) begin
                n_rem = n_rem - {1'b0, r_div_item[g].dvs};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_v[g+1] <= 1'b0;
            end else begin
                r_div_v[g+1] <= r_div_v[g];
            end
            r_div_item[g+1] <= r_div_item[g];
            r_div_rem[g+1]  <= n_rem[DVS_W-1:0];
        end
    end

    t_prod r_p1, r_p2, r_p3, r_p4, r_p5;
    t_prod n_p1, n_p2, n_p3, n_p4, n_p5;
    logic  r_v1, r_v2, r_v3, r_v4, r_v5;
    t_item n_fin;

    always_comb begin
        n_fin = r_div_item[NDIV];
        if (n_fin.need_div && (r_div_rem[NDIV] != '0)) begin
            n_fin.status = ST_INVALID;
        end
    end

    always_comb begin
        n_p1       = '0;
        n_p1.it    = n_fin;
        n_p1.inner = mul_wrap({56'd0, n_fin.e}, n_fin.f1);

        n_p2       = r_p1;
        n_p2.inner = mul_wrap(r_p1.inner, r_p1.it.f2);

        n_p3       = r_p2;
        n_p3.inner = mul_wrap(r_p2.inner, r_p2.it.f3);

        n_p4       = r_p3;
        n_p4.row   = mul_wrap(r_p3.inner, r_p3.it.len);
        n_p4.chunk = mul_wrap(r_p3.inner, r_p3.it.len >> r_p3.it.k);

        n_p5       = r_p4;
        n_p5.choff = r_p4.chunk * {60'd0, r_p4.it.rank};
        n_p5.total = r_p4.it.rank0 ? {56'd0, r_p4.it.e} : mul_wrap(r_p4.chunk, r_p4.it.outer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= r_div_v[NDIV];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
        r_p1 <= n_p1;
        r_p2 <= n_p2;
        r_p3 <= n_p3;
        r_p4 <= n_p4;
        r_p5 <= n_p5;
    end

    logic        ok;
    logic [31:0] ext;
    assign ok  = (r_p5.it.status == ST_OK);
    assign ext = r_p5.it.len >> r_p5.it.k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v5;
        end
        o_status_code        <= r_p5.it.status;
        o_split_dim          <= ok & r_p5.it.axis;
        o_shard_offset_elems <= ok ? {32'd0, ext * {28'd0, r_p5.it.rank}} : 64'd0;
        o_shard_extent_elems <= ok ? {32'd0, ext} : 64'd0;
        o_shard_size_bytes   <= ok ? r_p5.total : 64'd0;
        o_outer_row_count    <= ok ? {32'd0, r_p5.it.outer} : 64'd0;
        o_row_pitch          <= ok ? r_p5.row : 64'd0;
        o_chunk_size         <= ok ? r_p5.chunk : 64'd0;
        o_chunk_offset       <= ok ? r_p5.choff : 64'd0;
    end

endmodule

// ===== tb/tensor_parallel_shard_view_top_test.sv =====
// Self-checking testbench for tensor_parallel_shard_view_top: directed and random descriptors,
// per-phase register settings, results checked in order by a scoreboard class.
// Depends on tpsv_pkg and the tensor_parallel_shard_view_top RTL.
`timescale 1ns / 1ps

module tensor_parallel_shard_view_top_test;
    import tpsv_pkg::*;

    localparam int P_LIMIT   = MAX_RANK_DEF;
    localparam int LATENCY   = 45;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic [2:0]       rank;
        logic [3:0][31:0] dims;
        logic [7:0]       elem;
        logic [2:0]       cls;
        logic [31:0]      hblk;
    } view_in_t;

    typedef struct {
        logic [1:0]  status;
        logic        split;
        logic [63:0] off;
        logic [63:0] ext;
        logic [63:0] size;
        logic [63:0] outer;
        logic [63:0] pitch;
        logic [63:0] chunk;
        logic [63:0] choff;
    } view_out_t;

    class shard_view_board;
        logic [4:0]  degree;
        logic [3:0]  my_rank;
        logic [15:0] heads;
        logic [31:0] proj_block;
        view_out_t   expected_q[$];
        int          fails;

        function new();
            degree     = 5'd1;
            my_rank    = 4'd0;
            heads      = 16'd1;
            proj_block = 32'd1;
            fails      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_DEGREE: degree     = v[4:0];
                REG_RANK:   my_rank    = v[3:0];
                REG_HEADS:  heads      = v[15:0];
                REG_BLOCK:  proj_block = v;
                default: ;
            endcase
        endfunction

        function view_out_t shard_view(view_in_t x);
            view_out_t   r;
            logic [63:0] d[4];
            logic [63:0] deg, e, blk, len, cnt, per, other, inner, outer;
            logic [2:0]  c;
            logic        axis;
            int          n;
            r = '{default: '0};
            for (int i = 0; i < 4; i++) d[i] = {32'd0, x.dims[i]};
            deg = {59'd0, degree};
            e = {56'd0, x.elem};
            n = x.rank;
            c = (x.cls == 3'd7) ? CL_UNKNOWN : x.cls;
            axis = 1'b0;
            if (!(deg inside {64'd1, 64'd2, 64'd4, 64'd8, 64'd16})) r.status = ST_INVALID;
            else if ({60'd0, my_rank} >= deg) r.status = ST_INVALID;
            else if (heads == 0 || {48'd0, heads} % deg != 0) r.status = ST_INVALID;
            else if (n > ((P_LIMIT < 4) ? P_LIMIT : 4)) r.status = ST_INVALID;
            else if (x.cls == CL_CONCAT) r.status = ST_UNSUPPORTED;
            else if (deg == 1 || c == CL_REPLICATED) begin
                r.ext = d[0];
                r.size = e;
                for (int i = 0; i < n; i++) r.size = r.size * d[i];
            end else if (c == CL_UNKNOWN) r.status = ST_FAILED;
            else if (n < 2) r.status = ST_INVALID;
            else begin
                axis = (c == CL_IN_HEADS || c == CL_IN_DIM);
                case (c)
                    CL_OUT_HEADS: blk = {32'd0, x.hblk};
                    CL_IN_HEADS:  blk = {32'd0, proj_block};
                    default:      blk = 64'd1;
                endcase
                len = d[axis];
                if (blk == 0 || len % blk != 0) r.status = ST_INVALID;
                else begin
                    cnt = len / blk;
                    if (cnt % deg != 0) r.status = ST_INVALID;
                    else begin
                        per = cnt / deg;
                        r.split = axis;
                        r.off = {60'd0, my_rank} * per * blk;
                        r.ext = per * blk;
                        other = e;
                        for (int i = 0; i < n; i++) if (i != axis) other = other * d[i];
                        r.size = other * r.ext;
                    end
                end
            end
            if (r.status != ST_OK) return '{default: '0, status: r.status};
            inner = e;
            for (int i = r.split + 1; i < n; i++) inner = inner * d[i];
            outer = 64'd1;
            for (int i = 0; i < r.split; i++) outer = outer * d[i];
            r.outer = outer;
            r.pitch = d[r.split] * inner;
            r.chunk = r.ext * inner;
            r.choff = r.off * inner;
            return r;
        endfunction

        function void note_input(view_in_t x);
            expected_q.push_back(shard_view(x));
        endfunction

        function void field_cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, actual %0h", name, e, a);
                fails++;
            end
        endfunction

        function void check_result(view_out_t a);
            view_out_t e;
            if (expected_q.size() == 0) begin
                $error("result with no descriptor outstanding");
                fails++;
                return;
            end
            e = expected_q.pop_front();
            field_cmp("status_code", e.status, a.status);
            field_cmp("split_dim", e.split, a.split);
            field_cmp("shard_offset_elems", e.off, a.off);
            field_cmp("shard_extent_elems", e.ext, a.ext);
            field_cmp("shard_size_bytes", e.size, a.size);
            field_cmp("outer_row_count", e.outer, a.outer);
            field_cmp("row_pitch", e.pitch, a.pitch);
            field_cmp("chunk_size", e.chunk, a.chunk);
            field_cmp("chunk_offset", e.choff, a.choff);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_tensor_rank = '0;
    logic [31:0] i_dim0 = '0, i_dim1 = '0, i_dim2 = '0, i_dim3 = '0;
    logic [7:0]  i_elem_bytes = '0;
    logic [2:0]  i_shard_class = '0;
    logic [31:0] i_head_block_elems = '0;
    logic        o_valid;
    logic [1:0]  o_status_code;
    logic        o_split_dim;
    logic [63:0] o_shard_offset_elems, o_shard_extent_elems, o_shard_size_bytes;
    logic [63:0] o_outer_row_count, o_row_pitch, o_chunk_size, o_chunk_offset;

    tensor_parallel_shard_view_top #(.P_MAX_RANK(P_LIMIT)) u_dut (.*);

    shard_view_board board = new();
    int  transfers = 0;
    int  quiet_cycles = 0;
    bit  idling_on = 1'b1;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        view_in_t  cur;
        view_out_t res;
        if (i_rst_n) begin
            if (i_cfg_we) board.set_reg(i_cfg_idx, i_cfg_data);
            if (o_valid) begin
                res = '{o_status_code, o_split_dim, o_shard_offset_elems, o_shard_extent_elems,
                        o_shard_size_bytes, o_outer_row_count, o_row_pitch, o_chunk_size,
                        o_chunk_offset};
                board.check_result(res);
            end
            if (start && !busy) begin
                cur.rank = i_tensor_rank;
                cur.dims = {i_dim3, i_dim2, i_dim1, i_dim0};
                cur.elem = i_elem_bytes;
                cur.cls  = i_shard_class;
                cur.hblk = i_head_block_elems;
                board.note_input(cur);
                transfers++;
            end
            quiet_cycles = (o_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drive_item(view_in_t x);
        int seen;
        if (idling_on && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_tensor_rank      <= x.rank;
        i_dim0             <= x.dims[0];
        i_dim1             <= x.dims[1];
        i_dim2             <= x.dims[2];
        i_dim3             <= x.dims[3];
        i_elem_bytes       <= x.elem;
        i_shard_class      <= x.cls;
        i_head_block_elems <= x.hblk;
        start              <= 1'b1;
        seen = transfers;
        wait (transfers != seen);
    endtask

    // hold off until every outstanding result is back, then let the pipe drain
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic configure(logic [4:0] deg, logic [3:0] rk, logic [15:0] hd,
                             logic [31:0] blk);
        write_reg(REG_DEGREE, {27'd0, deg});
        write_reg(REG_RANK, {28'd0, rk});
        write_reg(REG_HEADS, {16'd0, hd});
        write_reg(REG_BLOCK, blk);
    endtask

    function automatic view_in_t noise_item();
        view_in_t x;
        x.rank = 3'($urandom);
        for (int i = 0; i < 4; i++) x.dims[i] = $urandom;
        x.elem = 8'($urandom);
        x.cls  = 3'($urandom);
        x.hblk = $urandom;
        return x;
    endfunction

    function automatic view_in_t split_item();
        view_in_t    x;
        logic [31:0] blk;
        logic        axis;
        x.rank = 3'($urandom_range(2, 4));
        for (int i = 0; i < 4; i++)
            x.dims[i] = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 300);
        x.elem = 8'($urandom);
        x.cls  = 3'($urandom_range(CL_OUT_HEADS, CL_IN_DIM));
        x.hblk = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 64);
        axis = (x.cls == CL_IN_HEADS || x.cls == CL_IN_DIM);
        case (x.cls)
            CL_OUT_HEADS: blk = x.hblk;
            CL_IN_HEADS:  blk = board.proj_block;
            default:      blk = 32'd1;
        endcase
        x.dims[axis] = blk * board.degree * $urandom_range(1, 8);
        if ($urandom_range(9) == 0) x.dims[axis] = x.dims[axis] + 1;
        return x;
    endfunction

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
            drive_item(($urandom_range(99) < 75) ? split_item() : noise_item());
    endtask

    task automatic run_directed(bit with_ranks);
        view_in_t x;
        x.dims = {4{32'hFFFF_FFFF}};
        x.elem = 8'hFF;
        x.hblk = 32'hFFFF_FFFF;
        x.rank = 3'd4;
        for (int c = 0; c < 8; c++) begin
            x.cls = 3'(c);
            drive_item(x);
        end
        if (with_ranks) begin
            x.cls = CL_OUT_DIM;
            x.dims = '0;
            x.elem = 8'd0;
            x.hblk = 32'd0;
            for (int r = 0; r < 8; r += 2) begin
                x.rank = 3'(r) | 3'(r >> 1);
                drive_item(x);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed(1'b1);
        drain();
        configure(5'd2, 4'd1, 16'd64, 32'd16);
        run_directed(1'b0);
        run_random(280);
        drain();
        idling_on = 1'b0;
        configure(5'd4, 4'd3, 16'd32, 32'd3);
        run_random(200);
        drain();
        idling_on = 1'b1;
        configure(5'd8, 4'd7, 16'd65528, 32'd5);
        run_random(200);
        drain();
        configure(5'd16, 4'd15, 16'd65520, 32'd1);
        run_random(200);
        drain();
        configure(5'd16, 4'd0, 16'd16, 32'hFFFF_FFFF);
        run_random(150);
        drain();
        configure(5'd1, 4'd0, 16'd65535, 32'd0);
        run_random(150);
        drain();
        configure(5'd3, 4'd0, 16'd12, 32'd1);
        run_random(30);
        drain();
        configure(5'd31, 4'd15, 16'd0, 32'd0);
        run_random(30);
        drain();
        configure(5'd8, 4'd8, 16'd8, 32'd2);
        run_random(30);
        drain();
        configure(5'd4, 4'd0, 16'd6, 32'd2);
        run_random(30);
        drain();
        configure(5'd2, 4'd0, 16'd0, 32'd7);
        run_random(30);
        drain();
        if (board.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
